// ----- rtl/f8rq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and queue entry layout for the FP8 E4M3 row quantizer.
// Depends on nothing; every other file of the block but the two interfaces imports it.
package f8rq_pkg;

    localparam int C_QDEPTH = 2;

    // Significand of the float32 constant 1/448 (0x3b124925), with the hidden bit.
    localparam logic [23:0] C_INV448_SIG   = 24'h924925;
    localparam logic [31:0] C_MIN_SCALE    = 32'h2b8cbccc;
    localparam logic [31:0] C_F32_INF      = 32'h7f800000;
    localparam logic [31:0] C_FP8_MAX_BITS = 32'h43e00000;
    localparam logic [31:0] C_SUBN_LIMIT   = 32'h3c800000;
    localparam logic [31:0] C_RND_BIAS     = 32'h0007ffff;
    localparam logic [31:0] C_E4M3_REBIAS  = 32'h3c000000;
    localparam logic [6:0]  C_NAN_MAG      = 7'h7f;
    localparam logic [7:0]  C_EXP_MAX      = 8'hff;
    localparam logic [4:0]  C_DIV_STEPS    = 5'd26;

    typedef enum logic [1:0] {
        K_MEASURE,
        K_MEASURE_LAST,
        K_ENCODE
    } t_kind;

    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_NORM,
        CLS_INF,
        CLS_NAN
    } t_cls;

    typedef struct packed {
        t_kind       kind;
        t_cls        cls;
        logic        sign;
        logic [14:0] mag;
    } t_qent;

    typedef struct packed {
        logic        busy;
        logic [31:0] inv;
    } t_recip_st;

endpackage

// ----- rtl/f8rq_req_if.sv -----
`timescale 1ns / 1ps
// Input channel of the FP8 E4M3 row quantizer: one bf16 element per beat.
// Depends on nothing.
interface f8rq_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] value;
    logic        last;

    modport source (output valid, req_type, value, last, input ready);
    modport sink (input valid, req_type, value, last, output ready);
endinterface

// ----- rtl/f8rq_res_if.sv -----
`timescale 1ns / 1ps
// Output channel of the FP8 E4M3 row quantizer: one scale or one fp8 code per beat.
// Depends on nothing.
interface f8rq_res_if;
    logic        valid;
    logic        ready;
    logic        is_scale;
    logic [7:0]  code;
    logic [31:0] scale_bits;

    modport source (output valid, is_scale, code, scale_bits, input ready);
    modport sink (input valid, is_scale, code, scale_bits, output ready);
endinterface

// ----- rtl/f8rq_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input beats and classifies each element into a queue entry.
// Depends on f8rq_pkg and f8rq_req_if.
module f8rq_front (
    f8rq_req_if.sink        i_req,
    input  logic            i_full,
    output logic            o_push,
    output f8rq_pkg::t_qent o_entry
);
    import f8rq_pkg::*;

    logic [7:0] w_exp;
    logic [6:0] w_man;
    logic       w_nan;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    assign w_exp = i_req.value[14:7];
    assign w_man = i_req.value[6:0];
    assign w_nan = (w_exp == C_EXP_MAX) && (w_man != 7'd0);

    always_comb begin
        o_entry.sign = i_req.value[15];
        // A NaN counts as zero toward the row maximum.
        o_entry.mag  = (!i_req.req_type && w_nan) ? 15'd0 : i_req.value[14:0];
        if (i_req.req_type) begin
            o_entry.kind = K_ENCODE;
        end else if (i_req.last) begin
            o_entry.kind = K_MEASURE_LAST;
        end else begin
            o_entry.kind = K_MEASURE;
        end
        if (w_exp == 8'd0) begin
            o_entry.cls = CLS_ZERO;
        end else if (w_exp == C_EXP_MAX) begin
            o_entry.cls = w_nan ? CLS_NAN : CLS_INF;
        end else begin
            o_entry.cls = CLS_NORM;
        end
    end
endmodule

// ----- rtl/f8rq_fifo.sv -----
`timescale 1ns / 1ps
// Small register queue that decouples the front end from the back end.
// Depends on f8rq_pkg for the entry type.
module f8rq_fifo #(
    parameter int DEPTH = f8rq_pkg::C_QDEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  f8rq_pkg::t_qent i_data,
    output logic            o_full,
    input  logic            i_pop,
    output f8rq_pkg::t_qent o_data,
    output logic            o_empty
);
    import f8rq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_qent         r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST_IDX) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ----- rtl/f8rq_recip.sv -----
`timescale 1ns / 1ps
// Float32 reciprocal of the row scale: restoring division, one quotient bit per cycle.
// Depends on f8rq_pkg.
module f8rq_recip (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_scale,
    output f8rq_pkg::t_recip_st o_st
);
    import f8rq_pkg::*;

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [24:0] r_rem;
    logic [25:0] r_q;
    logic [23:0] r_sig;
    logic [7:0]  r_es;
    logic [31:0] r_res;

    logic        w_ge;
    logic [24:0] w_diff;
    logic [24:0] n_rem;
    logic        w_inc;
    logic [7:0]  w_bexp;
    logic [30:0] w_rnd;
    logic [31:0] n_res;

    always_comb begin
        w_ge   = (r_rem >= {1'b0, r_sig});
        w_diff = w_ge ? (r_rem - {1'b0, r_sig}) : r_rem;
        n_rem  = {w_diff[23:0], 1'b0};
        // Quotient bit 25 is set only when the scale significand is exactly one.
        w_inc  = r_q[0] && ((r_rem != 25'd0) || r_q[1]);
        w_bexp = 8'd253 - r_es;
        w_rnd  = {w_bexp, r_q[23:1]} + {30'd0, w_inc};
        n_res  = r_q[25] ? {1'b0, 8'd254 - r_es, 23'd0} : {1'b0, w_rnd};
    end

    assign o_st.busy = r_busy;
    assign o_st.inv  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            if (i_scale[30:23] == C_EXP_MAX) begin
                r_res  <= 32'd0;
                r_busy <= 1'b0;
            end else begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_rem  <= 25'h0800000;
                r_q    <= 26'd0;
                r_sig  <= {1'b1, i_scale[22:0]};
                r_es   <= i_scale[30:23];
            end
        end else if (r_busy) begin
            if (r_cnt < C_DIV_STEPS) begin
                r_q   <= {r_q[24:0], w_ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt + 5'd1;
            end else begin
                r_res  <= n_res;
                r_busy <= 1'b0;
            end
        end
    end
endmodule

// ----- rtl/f8rq_back.sv -----
`timescale 1ns / 1ps
// Back end: row maximum, scale product and clamp, and the bf16 to e4m3fn encode path.
// Depends on f8rq_pkg, f8rq_res_if and the status of f8rq_recip.
module f8rq_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  f8rq_pkg::t_qent     i_entry,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_recip_start,
    output logic [31:0]         o_recip_scale,
    input  f8rq_pkg::t_recip_st i_recip,
    f8rq_res_if.source          o_res
);
    import f8rq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCL_MUL,
        ST_RND,
        ST_SCL_CLAMP,
        ST_SCL_WAIT,
        ST_ENC_CVT
    } t_state;

    t_state             r_state;
    logic [14:0]        r_amax;
    logic [14:0]        r_smax;
    logic [31:0]        r_inv;
    logic [31:0]        r_prod;
    logic signed [9:0]  r_pexp;
    logic               r_zero;
    logic               r_inf;
    logic               r_nan;
    logic               r_sign;
    logic               r_is_enc;
    logic [30:0]        r_mag;
    logic [31:0]        r_scale;
    logic               r_out_valid;
    logic               r_is_scale;
    logic [7:0]         r_code;
    logic [31:0]        r_scale_bits;

    logic               w_slot_free;
    logic [14:0]        n_max;
    logic               w_inv_zero;
    logic [31:0]        n_eprod;
    logic signed [9:0]  n_epexp;
    logic [31:0]        n_sprod;
    logic signed [9:0]  n_spexp;
    logic               w_hi;
    logic [23:0]        w_m24;
    logic               w_rb;
    logic               w_st;
    logic               w_inc;
    logic signed [9:0]  w_rexp;
    logic [30:0]        n_mag;
    logic [31:0]        n_scale;
    logic [30:0]        w_m31;
    logic [7:0]         w_ce;
    logic               w_sub_ok;
    logic [4:0]         w_sh;
    logic [23:0]        w_sig24;
    logic [23:0]        w_sq;
    logic               w_srb;
    logic               w_sst;
    logic [3:0]         w_code_sub;
    logic [31:0]        w_u;
    logic [31:0]        w_un;
    logic [6:0]         w_mag7;
    logic [7:0]         n_code;

    assign w_slot_free = !r_out_valid || o_res.ready;
    assign o_pop       = (r_state == ST_IDLE) && !i_empty;

    assign o_res.valid      = r_out_valid;
    assign o_res.is_scale   = r_is_scale;
    assign o_res.code       = r_code;
    assign o_res.scale_bits = r_scale_bits;

    assign o_recip_start = (r_state == ST_SCL_CLAMP);
    assign o_recip_scale = n_scale;

    always_comb begin
        n_max      = (i_entry.mag > r_amax) ? i_entry.mag : r_amax;
        w_inv_zero = (r_inv[30:23] == 8'd0);
        n_eprod    = {24'd0, 1'b1, i_entry.mag[6:0]} * {8'd0, 1'b1, r_inv[22:0]};
        n_epexp    = $signed({2'b00, i_entry.mag[14:7]}) + $signed({2'b00, r_inv[30:23]})
                     - 10'sd127;
        n_sprod    = {24'd0, 1'b1, r_smax[6:0]} * {8'd0, C_INV448_SIG};
        n_spexp    = $signed({2'b00, r_smax[14:7]}) - 10'sd9;

        // Round the 32-bit significand product to float32, nearest even.
        w_hi   = r_prod[31];
        w_m24  = w_hi ? r_prod[31:8] : r_prod[30:7];
        w_rb   = w_hi ? r_prod[7] : r_prod[6];
        w_st   = w_hi ? (r_prod[6:0] != 7'd0) : (r_prod[5:0] != 6'd0);
        w_inc  = w_rb && (w_st || w_m24[0]);
        w_rexp = r_pexp + $signed({9'd0, w_hi});
        if (r_zero || w_rexp <= 10'sd0) begin
            n_mag = 31'd0;
        end else if (r_inf || w_rexp > 10'sd254) begin
            n_mag = C_F32_INF[30:0];
        end else begin
            n_mag = {w_rexp[7:0], w_m24[22:0]} + {30'd0, w_inc};
        end

        n_scale = (r_mag > C_MIN_SCALE[30:0]) ? {1'b0, r_mag} : C_MIN_SCALE;

        // e4m3fn conversion of the saturated magnitude. Below 2^-10 everything rounds
        // to zero, so the subnormal shifter only covers exponents from 117 up.
        w_m31      = (r_mag > C_FP8_MAX_BITS[30:0]) ? C_FP8_MAX_BITS[30:0] : r_mag;
        w_ce       = w_m31[30:23];
        w_sub_ok   = (w_ce >= 8'd117);
        w_sh       = w_sub_ok ? 5'(8'd141 - w_ce) : 5'd24;
        w_sig24    = {1'b1, w_m31[22:0]};
        w_sq       = w_sig24 >> w_sh;
        w_srb      = w_sig24[w_sh - 5'd1];
        w_sst      = (w_sig24 & ((24'd1 << (w_sh - 5'd1)) - 24'd1)) != 24'd0;
        w_code_sub = {1'b0, w_sq[2:0]} + {3'd0, w_srb && (w_sst || w_sq[0])};
        w_u        = {1'b0, w_m31} + C_RND_BIAS + {31'd0, w_m31[20]};
        w_un       = w_u - C_E4M3_REBIAS;
        if (w_m31 < C_SUBN_LIMIT[30:0]) begin
            w_mag7 = w_sub_ok ? {3'd0, w_code_sub} : 7'd0;
        end else begin
            w_mag7 = w_un[26:20];
        end
        n_code = r_nan ? {r_sign, C_NAN_MAG} : {r_sign, w_mag7};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_amax      <= 15'd0;
        end else begin
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        unique case (i_entry.kind)
                            K_MEASURE: begin
                                r_amax <= n_max;
                            end
                            K_MEASURE_LAST: begin
                                r_amax  <= 15'd0;
                                r_smax  <= n_max;
                                r_state <= ST_SCL_MUL;
                            end
                            K_ENCODE: begin
                                r_prod   <= n_eprod;
                                r_pexp   <= n_epexp;
                                r_zero   <= (i_entry.cls == CLS_ZERO) || w_inv_zero;
                                r_inf    <= (i_entry.cls == CLS_INF);
                                // Infinity times zero gives the default NaN, sign set.
                                r_nan    <= (i_entry.cls == CLS_NAN) ||
                                            ((i_entry.cls == CLS_INF) && w_inv_zero);
                                r_sign   <= ((i_entry.cls == CLS_INF) && w_inv_zero) ?
                                            1'b1 : i_entry.sign;
                                r_is_enc <= 1'b1;
                                r_state  <= ST_RND;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SCL_MUL: begin
                    r_prod   <= n_sprod;
                    r_pexp   <= n_spexp;
                    r_zero   <= (r_smax[14:7] == 8'd0);
                    r_inf    <= (r_smax[14:7] == C_EXP_MAX);
                    r_nan    <= 1'b0;
                    r_sign   <= 1'b0;
                    r_is_enc <= 1'b0;
                    r_state  <= ST_RND;
                end
                ST_RND: begin
                    r_mag   <= n_mag;
                    r_state <= r_is_enc ? ST_ENC_CVT : ST_SCL_CLAMP;
                end
                ST_SCL_CLAMP: begin
                    r_scale <= n_scale;
                    r_state <= ST_SCL_WAIT;
                end
                ST_SCL_WAIT: begin
                    if (!i_recip.busy && w_slot_free) begin
                        r_inv        <= i_recip.inv;
                        r_out_valid  <= 1'b1;
                        r_is_scale   <= 1'b1;
                        r_code       <= 8'd0;
                        r_scale_bits <= r_scale;
                        r_state      <= ST_IDLE;
                    end
                end
                ST_ENC_CVT: begin
                    if (w_slot_free) begin
                        r_out_valid  <= 1'b1;
                        r_is_scale   <= 1'b0;
                        r_code       <= n_code;
                        r_scale_bits <= 32'd0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- rtl/fp8_e4m3_row_quantizer_core.sv -----
`timescale 1ns / 1ps
// Per-row absmax quantizer from bf16 to FP8 E4M3FN with a float32 row scale.
// An encode beat gives its code from state ST_ENC_CVT; a measure beat that
// is not last gives no result; the last one gives the scale when the divider is done.
// Throughput: one measure beat per cycle while the back end idles; an encode beat holds the
// back end through ST_RND and ST_ENC_CVT; a row end holds it until the divider is done.
// Reset is synchronous, active low: it clears the queue, the row maximum and the output.
//
// Depends on f8rq_pkg, f8rq_req_if, f8rq_res_if, f8rq_front, f8rq_fifo, f8rq_recip
// and f8rq_back.
//
// Structure. The front end classifies each beat (measure, measure with last, encode) and
// flags zero, infinity and NaN. A small queue holds the classified beats, so the input
// keeps flowing while the back end works. The back end keeps the running maximum as a
// 15-bit magnitude, since positive floats order like integers. At the row end it
// multiplies the maximum by the significand of 1/448, rounds to float32, clamps at 1e-12
// and starts the reciprocal unit. The scale beat leaves together with the update of the
// kept inverse scale, so a following encode beat always sees the new value.
// Encode beats are multiplied by the inverse scale, rounded to float32, saturated at 448
// and rounded to e4m3fn, with subnormal codes below 2^-6.
// The inverse scale has no reset value: encoding before the first row end gives codes
// from an unwritten register.
module fp8_e4m3_row_quantizer_core #(
    parameter int QDEPTH = f8rq_pkg::C_QDEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    f8rq_req_if.sink   i_req,
    f8rq_res_if.source o_res
);
    import f8rq_pkg::*;

    t_qent       w_push_entry;
    t_qent       w_head_entry;
    logic        w_push;
    logic        w_pop;
    logic        w_full;
    logic        w_empty;
    logic        w_recip_start;
    logic [31:0] w_recip_scale;
    t_recip_st   w_recip_st;

    f8rq_front u_front (
        .i_req   (i_req),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    f8rq_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head_entry),
        .o_empty (w_empty)
    );

    f8rq_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_recip_start),
        .i_scale (w_recip_scale),
        .o_st    (w_recip_st)
    );

    f8rq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (w_head_entry),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .o_recip_start (w_recip_start),
        .o_recip_scale (w_recip_scale),
        .i_recip       (w_recip_st),
        .o_res         (o_res)
    );
endmodule

// ----- rtl/f8rq_checker.sv -----
`timescale 1ns / 1ps
// Port-level assertions for the FP8 E4M3 row quantizer, bound to the top level.
// Depends on f8rq_pkg and fp8_e4m3_row_quantizer_core.
module f8rq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_is_scale,
    input logic [7:0]  i_code,
    input logic [31:0] i_scale_bits
);
    import f8rq_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_code) &&
        $stable(i_scale_bits) && $stable(i_is_scale))
        else $error("result beat changed while stalled");

    a_scale_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_scale |-> !i_scale_bits[31] &&
        (i_scale_bits[30:0] >= C_MIN_SCALE[30:0]))
        else $error("row scale below the clamp floor or negative");

    a_field_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_is_scale && i_code == 8'd0) ||
        (!i_is_scale && i_scale_bits == 32'd0))
        else $error("unused result field not zero");

    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result beat right after reset");
endmodule

bind fp8_e4m3_row_quantizer_core f8rq_checker u_f8rq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_is_scale   (o_res.is_scale),
    .i_code       (o_res.code),
    .i_scale_bits (o_res.scale_bits)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for fp8_e4m3_row_quantizer_core: rows of bf16 beats, measure then encode.
// Depends on f8rq_pkg, f8rq_req_if, f8rq_res_if and the quantizer RTL.
module tb;
    import f8rq_pkg::*;

    localparam logic [31:0] C_INV448_BITS = 32'h3b124925;
    localparam logic [31:0] C_DEFAULT_NAN = 32'hffc00000;
    localparam int          C_ITEMS       = 1700;
    localparam int          C_IDLE_LIMIT  = 3000;

    typedef enum logic {
        OP_MEASURE = 1'b0,
        OP_ENCODE  = 1'b1
    } t_op;

    typedef struct {
        logic        is_scale;
        logic [7:0]  code;
        logic [31:0] scale_bits;
    } t_quant_res;

    // Predicts scales and fp8 codes from accepted beats and checks results in order.
    class quant_scoreboard;
        t_quant_res  awaiting[$];
        logic [14:0] absmax_mag;
        logic [31:0] inv_scale;
        int unsigned errors;
        int unsigned scales_seen;
        int unsigned codes_seen;

        function new();
            absmax_mag = '0;
            inv_scale  = '0;
            errors     = 0;
            scales_seen = 0;
            codes_seen = 0;
        endfunction

        function int pending();
            return awaiting.size();
        endfunction

        function real f32_to_real(logic [31:0] b);
            logic [63:0] d;
            logic [22:0] m;
            logic [10:0] e11;
            int sh;
            m = b[22:0];
            sh = 0;
            if (b[30:23] == 8'hff) begin
                d = {b[31], 11'h7ff, m, 29'b0};
            end else if (b[30:23] == 8'h00) begin
                if (m == 0) begin
                    d = {b[31], 63'b0};
                end else begin
                    while (!m[22]) begin
                        m = m << 1;
                        sh++;
                    end
                    e11 = 11'(1023 - 127 - sh);
                    d = {b[31], e11, m[21:0], 30'b0};
                end
            end else begin
                e11 = {3'b0, b[30:23]} + 11'd896;
                d = {b[31], e11, m, 29'b0};
            end
            return $bitstoreal(d);
        endfunction

        // Rounds a double to the nearest float32, ties to even, subnormals included.
        function logic [31:0] real_to_f32(real r);
            logic [63:0] d;
            logic [63:0] sig;
            logic [63:0] q;
            logic [63:0] rem;
            logic [63:0] half;
            int fe;
            int shift;
            d = $realtobits(r);
            if (d[62:52] == 11'h7ff) begin
                if (d[51:0] != 0)
                    return {d[63], 8'hff, 1'b1, d[50:29]};
                return {d[63], 8'hff, 23'b0};
            end
            if (d[62:52] == 11'h000)
                return {d[63], 31'b0};
            fe = int'(d[62:52]) - 1023 + 127;
            sig = {11'b0, 1'b1, d[51:0]};
            shift = (fe >= 1) ? 29 : 29 + 1 - fe;
            if (shift > 60)
                return {d[63], 31'b0};
            q = sig >> shift;
            rem = sig & ((64'd1 << shift) - 1);
            half = 64'd1 << (shift - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 1;
            if (fe >= 1) begin
                if (q[24]) begin
                    q = q >> 1;
                    fe++;
                end
                if (fe >= 255)
                    return {d[63], 8'hff, 23'b0};
                return {d[63], 8'(fe), q[22:0]};
            end
            return {d[63], q[30:0]};
        endfunction

        function logic [7:0] to_e4m3(logic [31:0] p);
            logic [31:0] mb;
            logic [31:0] u;
            logic [31:0] code;
            real r;
            int n;
            mb = {1'b0, p[30:0]};
            if (mb > C_F32_INF)
                return {p[31], C_NAN_MAG};
            if (mb > C_FP8_MAX_BITS)
                mb = C_FP8_MAX_BITS;
            if (mb < C_SUBN_LIMIT) begin
                // Exact in double, so the tie test is exact too.
                r = f32_to_real(mb) * 512.0;
                n = $rtoi(r);
                if ((r - n) > 0.5 || ((r - n) == 0.5 && n % 2 == 1))
                    n++;
                code = n;
            end else begin
                u = mb + C_RND_BIAS + ((mb >> 20) & 32'd1);
                code = (u - C_E4M3_REBIAS) >> 20;
            end
            return {p[31], code[6:0]};
        endfunction

        function void note_input(logic op, logic [15:0] value, logic last);
            t_quant_res x;
            logic [14:0] mag;
            logic [31:0] scale;
            logic [31:0] vb;
            logic [31:0] prod;
            if (op == OP_MEASURE) begin
                mag = value[14:0];
                if (mag > 15'h7f80)
                    mag = '0;
                if (mag > absmax_mag)
                    absmax_mag = mag;
                if (!last)
                    return;
                scale = real_to_f32(f32_to_real({1'b0, absmax_mag, 16'b0}) *
                                    f32_to_real(C_INV448_BITS));
                if (!(scale > C_MIN_SCALE))
                    scale = C_MIN_SCALE;
                inv_scale = real_to_f32(1.0 / f32_to_real(scale));
                absmax_mag = '0;
                x.is_scale = 1'b1;
                x.code = '0;
                x.scale_bits = scale;
            end else begin
                vb = {value, 16'b0};
                if (vb[30:0] > C_F32_INF[30:0])
                    prod = vb;
                else if (vb[30:0] == C_F32_INF[30:0] && inv_scale[30:0] == 0)
                    prod = C_DEFAULT_NAN;   // infinity times zero
                else
                    prod = real_to_f32(f32_to_real(vb) * f32_to_real(inv_scale));
                x.is_scale = 1'b0;
                x.code = to_e4m3(prod);
                x.scale_bits = '0;
            end
            awaiting.push_back(x);
        endfunction

        function void check_result(logic is_scale, logic [7:0] code, logic [31:0] sbits);
            t_quant_res x;
            if (awaiting.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result is_scale=%0d code=%02h scale=%08h",
                             is_scale, code, sbits);
                return;
            end
            x = awaiting.pop_front();
            if (is_scale) scales_seen++; else codes_seen++;
            if (x.is_scale !== is_scale || x.code !== code || x.scale_bits !== sbits) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: exp is_scale=%0d code=%02h scale=%08h, got %0d %02h %08h",
                             x.is_scale, x.code, x.scale_bits, is_scale, code, sbits);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    f8rq_req_if req_if();
    f8rq_res_if res_if();

    fp8_e4m3_row_quantizer_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    quant_scoreboard sb;
    int unsigned sent;
    int unsigned rows;
    int unsigned idle_cycles;
    int unsigned received;
    bit tx_burst;
    bit rx_burst;
    bit long_hold_done;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Ends the run if neither channel moves a beat for too long.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= C_IDLE_LIMIT) begin
            $display("ERROR: no beat moved for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_beat(t_op op, logic [15:0] value, logic last);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= op;
        req_if.value    <= value;
        req_if.last     <= last;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_input(op, value, last);
        sent++;
        if (sent % 64 == 0)
            tx_burst = ($urandom_range(0, 3) == 0);
    endtask

    task automatic receive_results();
        int w;
        forever begin
            if (!long_hold_done && received == 200) begin
                // Long back-pressure: the queue fills and the input must stall.
                w = 300;
                long_hold_done = 1'b1;
            end else begin
                w = rx_burst ? 0 : $urandom_range(0, 14);
            end
            if (w > 0) begin
                res_if.ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            sb.check_result(res_if.is_scale, res_if.code, res_if.scale_bits);
            received++;
            if (received % 50 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
        end
    endtask

    // Mostly values a few octaves below the row's top exponent, so codes spread widely.
    function automatic logic [15:0] pick_value(int top);
        int ex;
        case ($urandom_range(0, 11))
            0, 1: return 16'($urandom);
            2: begin
                case ($urandom_range(0, 5))
                    0: return 16'h7f80 | (16'($urandom_range(0, 1)) << 15);
                    1: return 16'h7fc0 | 16'($urandom_range(0, 63));
                    2: return 16'($urandom_range(0, 1)) << 15;
                    3: return 16'($urandom_range(1, 127));
                    4: return 16'h7f7f;
                    default: return 16'hff7f;
                endcase
            end
            default: begin
                ex = top - $urandom_range(0, 12);
                if (ex < 0) ex = 0;
                return {1'($urandom), 8'(ex), 7'($urandom)};
            end
        endcase
    endfunction

    task automatic run_row(int n, bit broken);
        logic [15:0] vals[16];
        int top;
        top = $urandom_range(1, 254);
        for (int i = 0; i < n; i++)
            vals[i] = pick_value(top);
        for (int i = 0; i < n; i++)
            send_beat(OP_MEASURE, vals[i], (i == n - 1) && !broken);
        if (broken)
            return;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0)
                vals[i] = pick_value(top);
            send_beat(OP_ENCODE, vals[i], 1'($urandom));
        end
        rows++;
    endtask

    initial begin
        sb = new();
        sent = 0;
        rows = 0;
        received = 0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        long_hold_done = 1'b0;
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.req_type    <= OP_MEASURE;
        req_if.value       <= '0;
        req_if.last        <= 1'b0;
        res_if.ready       <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            receive_results();
        join_none

        // Extremes: zeros of both signs, largest finite, subnormal, NaN, one.
        send_beat(OP_MEASURE, 16'h0000, 1'b0);
        send_beat(OP_MEASURE, 16'h8000, 1'b0);
        send_beat(OP_MEASURE, 16'hff7f, 1'b0);
        send_beat(OP_MEASURE, 16'h0001, 1'b0);
        send_beat(OP_MEASURE, 16'h7fc0, 1'b0);
        send_beat(OP_MEASURE, 16'h3f80, 1'b1);
        send_beat(OP_ENCODE, 16'h0000, 1'b0);
        send_beat(OP_ENCODE, 16'h8000, 1'b1);
        send_beat(OP_ENCODE, 16'h7f7f, 1'b0);
        send_beat(OP_ENCODE, 16'hff7f, 1'b0);
        send_beat(OP_ENCODE, 16'h0001, 1'b0);
        send_beat(OP_ENCODE, 16'hffc1, 1'b0);
        send_beat(OP_ENCODE, 16'h3f80, 1'b0);
        // An infinite row gives an infinite scale and a zero inverse.
        send_beat(OP_MEASURE, 16'hff80, 1'b1);
        send_beat(OP_ENCODE, 16'h7f80, 1'b0);
        send_beat(OP_ENCODE, 16'h3f80, 1'b1);
        // An all-zero row clamps the scale to its floor, so encodes of magnitude one or more saturate.
        send_beat(OP_MEASURE, 16'h0000, 1'b1);
        send_beat(OP_ENCODE, 16'h0001, 1'b0);
        send_beat(OP_ENCODE, 16'h3f80, 1'b0);
        send_beat(OP_ENCODE, 16'hbf80, 1'b0);
        send_beat(OP_ENCODE, 16'hff80, 1'b0);

        while (sent < C_ITEMS) begin
            if (rows == 60) begin
                // Let the block drain completely before the next row.
                req_if.valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
                rows++;
            end
            case ($urandom_range(0, 9))
                0: send_beat(t_op'($urandom_range(0, 1)), 16'($urandom), 1'($urandom));
                1: run_row($urandom_range(1, 6), 1'b1);
                2: run_row($urandom_range(9, 16), 1'b0);
                default: run_row($urandom_range(1, 8), 1'b0);
            endcase
        end
        req_if.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Run: %0d beats sent over %0d rows; %0d scales and %0d fp8 codes checked.",
                 sent, rows, sb.scales_seen, sb.codes_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Mismatches: %0d, results still missing: %0d", sb.errors, sb.pending());
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
